>>> hw/rtl/rbp_pkg.sv
// Shared types and codes for the refcounted block pool unit.
// Depends on nothing; used by the top level in hw/rtl and by the testbench.
package rbp_pkg;

   typedef enum logic [2:0] {
      FUNC_ALLOC  = 3'd0,
      FUNC_HOLD   = 3'd1,
      FUNC_UNHOLD = 3'd2,
      FUNC_REF    = 3'd3,
      FUNC_UNREF  = 3'd4
   } func_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_NOBLOCK = 2'd1,
      ST_NOSLOT  = 2'd2,
      ST_MISUSE  = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_READ,
      S_EXEC,
      S_LINK,
      S_OUT
   } state_type;

endpackage

>>> hw/rtl/rbp_block_mem.sv
// Per-block table: free link, hold count, ref count and slot, one word per block.
// Does not import rbp_pkg; plain synchronous RAM with one write port and one read port.
module rbp_block_mem #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

>>> hw/rtl/rbp_slot_mem.sv
// Per-slot table: owner block and the LRU prev/next links.
// One read port and one write port; synchronous, registered read.
module rbp_slot_mem #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

>>> hw/rtl/refcounted_block_pool_window_lru_unit.sv
// Top level of the refcounted block pool with an LRU window slot cache.
// A request beat passes through S_READ (read block entry), S_EXEC, S_LINK (decide, then
// up to four slot-link steps through the slot memory) and S_OUT, which forms the result.
// One beat is in flight at a time; the next request is taken the cycle after the result
// leaves. After reset a clearing pass loads the free block list and the slot LRU list;
// req_tready stays low until it ends.
module refcounted_block_pool_window_lru_unit #(
   parameter int PHYS_BLOCKS  = 1024,
   parameter int WINDOW_SLOTS = 256,
   parameter int COUNT_BITS   = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // func[2:0], block[12:3]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata    // status, block_index, slot_index, hold_level,
                                    // ref_level, blocks_used, blocks_peak,
                                    // slots_used, slots_peak
);
   import rbp_pkg::*;

   localparam int BW = $clog2(PHYS_BLOCKS + 1);
   localparam int BA = $clog2(PHYS_BLOCKS);
   localparam int SW = $clog2(WINDOW_SLOTS + 1);
   localparam int SA = $clog2(WINDOW_SLOTS);
   localparam int CB = COUNT_BITS;
   localparam int BMW = BW + 2 * CB + SW;
   localparam int SMW = BW + 2 * SW;
   localparam int IW = (PHYS_BLOCKS > WINDOW_SLOTS) ? BW : SW;
   localparam logic [BW-1:0] BNIL = BW'(PHYS_BLOCKS);
   localparam logic [SW-1:0] SNIL = SW'(WINDOW_SLOTS);
   localparam logic [CB-1:0] CMAX = '1;

   state_type state_ff, state_in;
   logic [IW-1:0] init_ff, init_in;
   logic [2:0] func_ff, func_in;
   logic [9:0] blk_ff, blk_in;
   logic [BW-1:0] top_ff, top_in;
   logic [SW-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [BW-1:0] nb_ff, nb_in, pb_ff, pb_in;
   logic [SW-1:0] ns_ff, ns_in, ps_ff, ps_in;
   logic [BW-1:0] link_ff, link_in;
   logic [CB-1:0] hold_ff, hold_in, rcnt_ff, rcnt_in;
   logic [SW-1:0] bslot_ff, bslot_in;
   logic [1:0] status_ff, status_in;
   logic have_ff, have_in, live_ff, live_in;
   logic [2:0] step_ff, step_in;
   logic [SW-1:0] sl_ff, sl_in, sp_ff, sp_in, sn_ff, sn_in;
   logic [BW-1:0] so_ff, so_in;
   logic [95:0] out_ff, out_in;
   logic out_v_ff, out_v_in;

   logic bm_we;
   logic [BA-1:0] bm_wa, bm_ra;
   logic [BMW-1:0] bm_wd, bm_rd;
   logic sm_we;
   logic [SA-1:0] sm_wa, sm_ra;
   logic [SMW-1:0] sm_wd, sm_rd;

   rbp_block_mem #(.DEPTH(PHYS_BLOCKS), .WIDTH(BMW)) u_bmem (
      .clock, .wr_en(bm_we), .wr_addr(bm_wa), .wr_data(bm_wd),
      .rd_addr(bm_ra), .rd_data(bm_rd));
   rbp_slot_mem #(.DEPTH(WINDOW_SLOTS), .WIDTH(SMW)) u_smem (
      .clock, .wr_en(sm_we), .wr_addr(sm_wa), .wr_data(sm_wd),
      .rd_addr(sm_ra), .rd_data(sm_rd));

   // Slot word: {owner, prev, next}. Block word: {link, hold, ref, slot}.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         init_ff  <= '0;
         top_ff   <= '0;
         head_ff  <= '0;
         tail_ff  <= SW'(WINDOW_SLOTS - 1);
         nb_ff <= '0; pb_ff <= '0; ns_ff <= '0; ps_ff <= '0;
         out_v_ff <= 1'b0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in; init_ff <= init_in; top_ff <= top_in;
         head_ff <= head_in; tail_ff <= tail_in;
         nb_ff <= nb_in; pb_ff <= pb_in; ns_ff <= ns_in; ps_ff <= ps_in;
         out_v_ff <= out_v_in; step_ff <= step_in;
      end
      func_ff <= func_in; blk_ff <= blk_in; link_ff <= link_in;
      hold_ff <= hold_in; rcnt_ff <= rcnt_in; bslot_ff <= bslot_in;
      status_ff <= status_in; have_ff <= have_in; live_ff <= live_in;
      sl_ff <= sl_in; sp_ff <= sp_in; sn_ff <= sn_in; so_ff <= so_in;
      out_ff <= out_in;
   end

   always_comb begin
      logic [BW-1:0] sowner;
      logic [SW-1:0] sprev, snext, ds;
      logic [BW-1:0] nb2;
      logic [SW-1:0] ns2;
      state_in = state_ff; init_in = init_ff; top_in = top_ff;
      head_in = head_ff; tail_in = tail_ff;
      nb_in = nb_ff; pb_in = pb_ff; ns_in = ns_ff; ps_in = ps_ff;
      func_in = func_ff; blk_in = blk_ff; link_in = link_ff;
      hold_in = hold_ff; rcnt_in = rcnt_ff; bslot_in = bslot_ff;
      status_in = status_ff; have_in = have_ff; live_in = live_ff;
      step_in = step_ff; sl_in = sl_ff; sp_in = sp_ff; sn_in = sn_ff; so_in = so_ff;
      out_in = out_ff; out_v_in = out_v_ff;
      bm_we = 1'b0; bm_wa = '0; bm_wd = '0; bm_ra = blk_ff[BA-1:0];
      sm_we = 1'b0; sm_wa = '0; sm_wd = '0; sm_ra = '0;
      req_tready = 1'b0;
      sowner = sm_rd[SMW-1 -: BW];
      sprev  = sm_rd[2*SW-1 -: SW];
      snext  = sm_rd[SW-1:0];
      ds = '0; nb2 = nb_ff; ns2 = ns_ff;
      if (out_v_ff && rsp_tready) out_v_in = 1'b0;
      case (state_ff)
         S_INIT: begin
            if (init_ff < IW'(PHYS_BLOCKS)) begin
               bm_we = 1'b1; bm_wa = init_ff[BA-1:0];
               bm_wd = {BW'(init_ff) + BW'(1), {CB{1'b0}}, {CB{1'b0}}, SNIL};
            end
            if (init_ff < IW'(WINDOW_SLOTS)) begin
               sm_we = 1'b1; sm_wa = init_ff[SA-1:0];
               sm_wd = {BNIL, (init_ff == '0) ? SNIL : SW'(init_ff) - SW'(1),
                        SW'(init_ff) + SW'(1)};
            end
            init_in = init_ff + IW'(1);
            if (init_ff == IW'(PHYS_BLOCKS > WINDOW_SLOTS ? PHYS_BLOCKS - 1
                                                           : WINDOW_SLOTS - 1))
               state_in = S_IDLE;
         end
         S_IDLE: begin
            req_tready = !out_v_ff;
            if (req_tvalid && !out_v_ff) begin
               func_in = req_tdata[2:0];
               blk_in  = req_tdata[12:3];
               state_in = S_READ;
            end
         end
         S_READ: begin
            bm_ra = (func_ff == FUNC_ALLOC) ? top_ff[BA-1:0] : blk_ff[BA-1:0];
            state_in = S_EXEC;
            if (func_ff == FUNC_ALLOC) blk_in = 10'(top_ff);
         end
         S_EXEC: begin
            {link_in, hold_in, rcnt_in, bslot_in} = bm_rd;
            sm_ra = bm_rd[SW-1:0] < SNIL ? bm_rd[SA-1:0] : head_ff[SA-1:0];
            state_in = S_LINK;
            step_in = '0;
         end
         default: begin
            // S_LINK: decide and run the slot-link updates, at most one slot write per step.
            // S_OUT: read back the block's slot owner and form the beat.
            if (state_ff == S_LINK && step_ff == 3'd0) begin
               status_in = ST_OK; have_in = 1'b1; step_in = 3'd7;
               sl_in = bslot_ff; sp_in = sprev; sn_in = snext; so_in = sowner;
               live_in = (bslot_ff < SNIL) && (sowner == BW'(blk_ff));
               if (func_ff == FUNC_ALLOC) begin
                  if (top_ff >= BNIL) begin
                     status_in = ST_NOBLOCK; blk_in = '0; have_in = 1'b0;
                  end else begin
                     top_in = link_ff; hold_in = CB'(1); link_in = BNIL;
                     nb2 = nb_ff + BW'(1);
                  end
               end else if (BW'(blk_ff) >= BNIL || func_ff > FUNC_UNREF) begin
                  status_in = ST_MISUSE; have_in = BW'(blk_ff) < BNIL;
               end else if (func_ff == FUNC_HOLD) begin
                  if (hold_ff == '0 || hold_ff == CMAX) status_in = ST_MISUSE;
                  else hold_in = hold_ff + CB'(1);
               end else if (func_ff == FUNC_UNHOLD) begin
                  if (hold_ff == '0 || (hold_ff == CB'(1) && rcnt_ff != '0))
                     status_in = ST_MISUSE;
                  else begin
                     hold_in = hold_ff - CB'(1);
                     if (hold_ff == CB'(1)) begin
                        link_in = top_ff; top_in = BW'(blk_ff);
                        if (nb_ff != '0) nb2 = nb_ff - BW'(1);
                     end
                  end
               end else if (func_ff == FUNC_REF) begin
                  if (hold_ff == '0 || rcnt_ff == CMAX) status_in = ST_MISUSE;
                  else if (rcnt_ff != '0) rcnt_in = rcnt_ff + CB'(1);
                  else if ((bslot_ff < SNIL) && (sowner == BW'(blk_ff))) begin
                     rcnt_in = CB'(1); ns2 = ns_ff + SW'(1); step_in = 3'd1;
                  end else if (head_ff >= SNIL) status_in = ST_NOSLOT;
                  else begin
                     rcnt_in = CB'(1); ns2 = ns_ff + SW'(1); step_in = 3'd1;
                     sl_in = head_ff; bslot_in = head_ff; so_in = BW'(blk_ff);
                  end
               end else begin
                  if (rcnt_ff == '0) status_in = ST_MISUSE;
                  else begin
                     rcnt_in = rcnt_ff - CB'(1);
                     if (rcnt_ff == CB'(1)) begin
                        if (ns_ff != '0) ns2 = ns_ff - SW'(1);
                        if ((bslot_ff < SNIL) && (sowner == BW'(blk_ff)))
                           step_in = 3'd4;
                     end
                  end
               end
               // The head read may differ from the reused slot; refetch if so.
               if (func_ff == FUNC_REF && step_in == 3'd1 && !(bslot_ff < SNIL
                   && sowner == BW'(blk_ff)) && !(bslot_ff == head_ff)) begin
                  step_in = 3'd6; sm_ra = head_ff[SA-1:0];
               end
               nb_in = nb2; ns_in = ns2;
               if (nb2 > pb_ff) pb_in = nb2;
               if (ns2 > ps_ff) ps_in = ns2;
            end else if (state_ff == S_LINK) begin
               case (step_ff)
                  3'd6: begin
                     sp_in = sprev; sn_in = snext; step_in = 3'd1;
                  end
                  3'd1: begin
                     // Unlink sl: fix prev's next (or head).
                     sm_we = 1'b1; sm_wa = sl_ff[SA-1:0];
                     sm_wd = {so_ff, SNIL, SNIL};
                     if (sp_ff >= SNIL) head_in = sn_ff;
                     else sm_ra = sp_ff[SA-1:0];
                     step_in = 3'd2;
                  end
                  3'd2: begin
                     if (sp_ff < SNIL) begin
                        sm_we = 1'b1; sm_wa = sp_ff[SA-1:0];
                        sm_wd = {sowner, sprev, sn_ff};
                     end
                     if (sn_ff >= SNIL) tail_in = sp_ff;
                     else sm_ra = sn_ff[SA-1:0];
                     step_in = 3'd3;
                  end
                  3'd3: begin
                     if (sn_ff < SNIL) begin
                        sm_we = 1'b1; sm_wa = sn_ff[SA-1:0];
                        sm_wd = {sowner, sp_ff, snext};
                     end
                     step_in = 3'd7;
                  end
                  3'd4: begin
                     // Append sl at the tail.
                     sm_we = 1'b1; sm_wa = sl_ff[SA-1:0];
                     sm_wd = {so_ff, tail_ff, SNIL};
                     if (tail_ff >= SNIL) head_in = sl_ff;
                     else sm_ra = tail_ff[SA-1:0];
                     step_in = 3'd5;
                  end
                  3'd5: begin
                     if (tail_ff < SNIL) begin
                        sm_we = 1'b1; sm_wa = tail_ff[SA-1:0];
                        sm_wd = {sowner, sprev, sl_ff};
                     end
                     tail_in = sl_ff; step_in = 3'd7;
                  end
                  default: begin
                     if (have_ff) begin
                        bm_we = 1'b1; bm_wa = blk_ff[BA-1:0];
                        bm_wd = {link_ff, hold_ff, rcnt_ff, bslot_ff};
                     end
                     sm_ra = bslot_ff[SA-1:0];
                     state_in = S_OUT;
                  end
               endcase
            end else begin
               live_in = (bslot_ff < SNIL) && (sowner == BW'(blk_ff)) && have_ff;
               ds = live_in ? bslot_ff : '0;
               out_in = '0;
               out_in[1:0]   = status_ff;
               out_in[11:2]  = blk_ff;
               out_in[19:12] = ds[7:0];
               out_in[35:20] = have_ff ? 16'(hold_ff) : 16'd0;
               out_in[51:36] = have_ff ? 16'(rcnt_ff) : 16'd0;
               out_in[62:52] = 11'(nb_ff);
               out_in[73:63] = 11'(pb_ff);
               out_in[82:74] = 9'(ns_ff);
               out_in[91:83] = 9'(ps_ff);
               out_v_in = 1'b1;
               state_in = S_IDLE;
            end
         end
      endcase
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_ff;

   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> state_ff == S_IDLE && !out_v_ff) else $error("ready while busy");
   a_peak_blocks: assert property (@(posedge clock) disable iff (reset)
      pb_ff >= nb_ff) else $error("block peak below use");
   a_peak_slots: assert property (@(posedge clock) disable iff (reset)
      ps_ff >= ns_ff) else $error("slot peak below use");
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !rsp_tvalid) else $error("early result");
endmodule

>>> tb/tb_top.sv
// Self-checking testbench for refcounted_block_pool_window_lru_unit.
// Drives a directed command table, a back-to-back burst, an exhaustion pass and then random
// traffic. A built-in block pool model predicts every result beat. Depends only on rbp_pkg and the unit itself.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import rbp_pkg::*;

   localparam int NB = 1024;
   localparam int NS = 256;
   localparam int CMAX = 65535;
   localparam int WD_LIMIT = 20000;

   typedef struct packed {
      logic [8:0]  speak;
      logic [8:0]  sused;
      logic [10:0] bpeak;
      logic [10:0] bused;
      logic [15:0] refl;
      logic [15:0] hold;
      logic [7:0]  slot;
      logic [9:0]  blk;
      status_type  st;
   } pool_rsp_t;

   typedef struct {
      logic [2:0]  f;
      logic [9:0]  b;
      bit          chk;
      status_type  st;
      logic [15:0] h;
      logic [15:0] r;
   } cmd_row_t;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [95:0] rsp_tdata;

   refcounted_block_pool_window_lru_unit uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always #5 clock = ~clock;

   // Shadow copy of the pool state.
   logic [10:0] free_next [NB];
   logic [10:0] free_head;
   logic [15:0] hold_cnt [NB];
   logic [15:0] ref_cnt [NB];
   logic [8:0]  blk_slot [NB];
   logic [10:0] slot_blk [NS];
   logic [8:0]  lru_prev [NS];
   logic [8:0]  lru_next [NS];
   logic [8:0]  lru_head, lru_tail;
   logic [10:0] n_blk, pk_blk;
   logic [8:0]  n_slot, pk_slot;

   pool_rsp_t pending_rsp [$];
   int        errors = 0;
   bit        idle_on = 0;
   bit        tx_idle_on = 0;

   function automatic bit slot_live(int b);
      return blk_slot[b] < NS && slot_blk[blk_slot[b]] == b;
   endfunction

   task automatic lru_unlink(int s);
      int p, n;
      p = lru_prev[s];
      n = lru_next[s];
      if (p >= NS) lru_head = 9'(n); else lru_next[p] = 9'(n);
      if (n >= NS) lru_tail = 9'(p); else lru_prev[n] = 9'(p);
      lru_prev[s] = 9'(NS);
      lru_next[s] = 9'(NS);
   endtask

   task automatic lru_push_tail(int s);
      lru_prev[s] = lru_tail;
      lru_next[s] = 9'(NS);
      if (lru_tail >= NS) lru_head = 9'(s); else lru_next[lru_tail] = 9'(s);
      lru_tail = 9'(s);
   endtask

   task automatic pool_init();
      for (int i = 0; i < NB; i++) begin
         free_next[i] = 11'(i + 1);
         hold_cnt[i] = '0;
         ref_cnt[i] = '0;
         blk_slot[i] = 9'(NS);
      end
      for (int i = 0; i < NS; i++) begin
         slot_blk[i] = 11'(NB);
         lru_prev[i] = (i == 0) ? 9'(NS) : 9'(i - 1);
         lru_next[i] = 9'(i + 1);
      end
      free_head = '0;
      lru_head = '0;
      lru_tail = 9'(NS - 1);
      n_blk = '0; pk_blk = '0; n_slot = '0; pk_slot = '0;
   endtask

   task automatic pool_step(input logic [2:0] f, input logic [9:0] bi, output pool_rsp_t r);
      status_type st;
      bit have;
      int b, s;
      st = ST_OK;
      have = 0;
      b = bi;
      if (f == FUNC_ALLOC) begin
         if (free_head >= NB) begin
            st = ST_NOBLOCK;
            b = 0;
         end else begin
            b = free_head;
            free_head = free_next[b];
            free_next[b] = 11'(NB);
            hold_cnt[b] = 16'd1;
            n_blk++;
            if (n_blk > pk_blk) pk_blk = n_blk;
            have = 1;
         end
      end else begin
         have = 1;
         case (f)
            FUNC_HOLD: begin
               if (hold_cnt[b] == 0 || hold_cnt[b] == CMAX) st = ST_MISUSE;
               else hold_cnt[b]++;
            end
            FUNC_UNHOLD: begin
               if (hold_cnt[b] == 0 || (hold_cnt[b] == 1 && ref_cnt[b] != 0)) begin
                  st = ST_MISUSE;
               end else begin
                  hold_cnt[b]--;
                  if (hold_cnt[b] == 0) begin
                     free_next[b] = free_head;
                     free_head = 11'(b);
                     if (n_blk != 0) n_blk--;
                  end
               end
            end
            FUNC_REF: begin
               if (hold_cnt[b] == 0 || ref_cnt[b] == CMAX) begin
                  st = ST_MISUSE;
               end else if (ref_cnt[b] != 0) begin
                  ref_cnt[b]++;
               end else if (slot_live(b)) begin
                  lru_unlink(blk_slot[b]);
                  ref_cnt[b] = 16'd1;
                  n_slot++;
                  if (n_slot > pk_slot) pk_slot = n_slot;
               end else if (lru_head >= NS) begin
                  st = ST_NOSLOT;
               end else begin
                  s = lru_head;
                  lru_unlink(s);
                  slot_blk[s] = 11'(b);
                  blk_slot[b] = 9'(s);
                  ref_cnt[b] = 16'd1;
                  n_slot++;
                  if (n_slot > pk_slot) pk_slot = n_slot;
               end
            end
            FUNC_UNREF: begin
               if (ref_cnt[b] == 0) begin
                  st = ST_MISUSE;
               end else begin
                  ref_cnt[b]--;
                  if (ref_cnt[b] == 0) begin
                     if (slot_live(b)) lru_push_tail(blk_slot[b]);
                     if (n_slot != 0) n_slot--;
                  end
               end
            end
            default: st = ST_MISUSE;
         endcase
      end
      r.st = st;
      r.blk = 10'(b);
      r.slot = (have && slot_live(b)) ? blk_slot[b][7:0] : '0;
      r.hold = have ? hold_cnt[b] : '0;
      r.refl = have ? ref_cnt[b] : '0;
      r.bused = n_blk;
      r.bpeak = pk_blk;
      r.sused = n_slot;
      r.speak = pk_slot;
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // Sends one command beat; the expectation is queued when the beat is accepted.
   task automatic send_cmd(input logic [2:0] f, input logic [9:0] b, input bit chk,
                           input status_type st, input logic [15:0] h, input logic [15:0] r);
      pool_rsp_t e;
      int n;
      @(negedge clock);
      if (tx_idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid = 0;
         n = $urandom_range(1, 4);
         repeat (n) @(negedge clock);
      end
      req_tvalid = 1;
      req_tdata = {3'b000, b, f};
      do @(posedge clock); while (!req_tready);
      pool_step(f, b, e);
      if (chk) begin
         e.st = st;
         e.hold = h;
         e.refl = r;
      end
      pending_rsp.push_back(e);
   endtask

   task automatic send(input logic [2:0] f, input logic [9:0] b);
      send_cmd(f, b, 0, ST_OK, 0, 0);
   endtask

   function automatic logic [9:0] pick_held();
      int start;
      start = $urandom_range(0, NB - 1);
      for (int k = 0; k < NB; k++)
         if (hold_cnt[(start + k) % NB] != 0) return 10'((start + k) % NB);
      return 10'(start);
   endfunction

   // Result channel backpressure.
   int stall_left = 0;
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
         stall_left <= $urandom_range(0, 3);
         rsp_tready <= 0;
      end else begin
         rsp_tready <= 1;
      end
   end

   always @(posedge clock) begin
      pool_rsp_t got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[91:0];
         if (pending_rsp.size() == 0) begin
            report_mismatch("unexpected beat", 1, 0);
         end else begin
            want = pending_rsp.pop_front();
            if (got.st != want.st) report_mismatch("status", got.st, want.st);
            if (got.blk != want.blk) report_mismatch("block_index", got.blk, want.blk);
            if (got.slot != want.slot) report_mismatch("slot_index", got.slot, want.slot);
            if (got.hold != want.hold) report_mismatch("hold_level", got.hold, want.hold);
            if (got.refl != want.refl) report_mismatch("ref_level", got.refl, want.refl);
            if (got.bused != want.bused) report_mismatch("blocks_used", got.bused, want.bused);
            if (got.bpeak != want.bpeak) report_mismatch("blocks_peak", got.bpeak, want.bpeak);
            if (got.sused != want.sused) report_mismatch("slots_used", got.sused, want.sused);
            if (got.speak != want.speak) report_mismatch("slots_peak", got.speak, want.speak);
         end
      end
   end

   int quiet = 0;
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= WD_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   cmd_row_t directed [25] = '{
      '{FUNC_HOLD,   10'd0,    1, ST_MISUSE, 16'd0, 16'd0},
      '{FUNC_UNHOLD, 10'd0,    1, ST_MISUSE, 16'd0, 16'd0},
      '{FUNC_REF,    10'd0,    1, ST_MISUSE, 16'd0, 16'd0},
      '{FUNC_UNREF,  10'd0,    1, ST_MISUSE, 16'd0, 16'd0},
      '{FUNC_ALLOC,  10'd0,    1, ST_OK,     16'd1, 16'd0},
      '{FUNC_HOLD,   10'd0,    1, ST_OK,     16'd2, 16'd0},
      '{FUNC_REF,    10'd0,    1, ST_OK,     16'd2, 16'd1},
      '{FUNC_REF,    10'd0,    1, ST_OK,     16'd2, 16'd2},
      '{FUNC_UNREF,  10'd0,    1, ST_OK,     16'd2, 16'd1},
      '{FUNC_UNREF,  10'd0,    1, ST_OK,     16'd2, 16'd0},
      '{FUNC_UNREF,  10'd0,    1, ST_MISUSE, 16'd2, 16'd0},
      '{FUNC_REF,    10'd0,    0, ST_OK,     16'd0, 16'd0},
      '{FUNC_UNREF,  10'd0,    0, ST_OK,     16'd0, 16'd0},
      '{FUNC_UNHOLD, 10'd0,    1, ST_OK,     16'd1, 16'd0},
      '{FUNC_UNHOLD, 10'd0,    1, ST_OK,     16'd0, 16'd0},
      '{3'd5,        10'd0,    1, ST_MISUSE, 16'd0, 16'd0},
      '{3'd6,        10'd1023, 1, ST_MISUSE, 16'd0, 16'd0},
      '{3'd7,        10'd512,  1, ST_MISUSE, 16'd0, 16'd0},
      '{FUNC_HOLD,   10'd1023, 1, ST_MISUSE, 16'd0, 16'd0},
      '{FUNC_ALLOC,  10'd0,    1, ST_OK,     16'd1, 16'd0},
      '{FUNC_ALLOC,  10'd1023, 1, ST_OK,     16'd1, 16'd0},
      '{FUNC_REF,    10'd0,    0, ST_OK,     16'd0, 16'd0},
      '{FUNC_UNHOLD, 10'd0,    1, ST_MISUSE, 16'd1, 16'd1},
      '{FUNC_UNREF,  10'd0,    0, ST_OK,     16'd0, 16'd0},
      '{FUNC_UNHOLD, 10'd0,    1, ST_OK,     16'd0, 16'd0}
   };

   initial begin
      logic [2:0] f;
      logic [9:0] b;
      int w;
      pool_init();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 0;
      idle_on = 1;
      tx_idle_on = 1;

      foreach (directed[i])
         send_cmd(directed[i].f, directed[i].b, directed[i].chk,
                  directed[i].st, directed[i].h, directed[i].r);

      // Back-to-back holds and references on block 1 at full rate.
      tx_idle_on = 0;
      idle_on = 0;
      repeat (4) send(FUNC_HOLD, 10'd1);
      repeat (4) send(FUNC_REF, 10'd1);
      idle_on = 1;
      tx_idle_on = 1;

      @(negedge clock);
      req_tvalid = 0;
      while (pending_rsp.size() != 0) @(posedge clock);

      // Exhaust the free list, then the window slots.
      repeat (NB + 4) send(FUNC_ALLOC, 10'd0);
      for (int i = 2; i < NS + 8; i++) send(FUNC_REF, 10'(i));
      for (int i = 2; i < NS + 8; i += 2) send(FUNC_UNREF, 10'(i));
      for (int i = 300; i < 500; i++) send(FUNC_UNHOLD, 10'(i));

      for (int i = 0; i < 400; i++) begin
         if (i == 360) begin
            idle_on = 0;
            tx_idle_on = 0;
         end
         w = $urandom_range(0, 99);
         if (w < 15) f = FUNC_ALLOC;
         else if (w < 30) f = FUNC_HOLD;
         else if (w < 50) f = FUNC_UNHOLD;
         else if (w < 75) f = FUNC_REF;
         else if (w < 95) f = FUNC_UNREF;
         else f = 3'($urandom_range(5, 7));
         b = ($urandom_range(0, 9) < 8) ? pick_held() : 10'($urandom_range(0, NB - 1));
         send(f, b);
      end

      @(negedge clock);
      req_tvalid = 0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (errors == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end
endmodule

>>> refcounted_block_pool_window_lru_unit.f
hw/rtl/rbp_pkg.sv
hw/rtl/rbp_block_mem.sv
hw/rtl/rbp_slot_mem.sv
hw/rtl/refcounted_block_pool_window_lru_unit.sv
tb/tb_top.sv
